>>> rtl/sdspi_pkg.sv
// shared types and constants for the sd card spi init sequencer
`default_nettype none

package sdspi_pkg;

   // configuration port geometry
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes (byte address bit 2)
   localparam logic [0:0] REG_RETRY_LIMIT  = 1'b0;
   localparam logic [0:0] REG_BLOCK_LENGTH = 1'b1;

   // register reset values
   localparam logic [7:0]  RETRY_LIMIT_RST  = 8'd100;
   localparam logic [11:0] BLOCK_LENGTH_RST = 12'd512;

   // sequencer phases
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_CMD0   = 3'd1,
      PH_CMD8   = 3'd2,
      PH_CMD55  = 3'd3,
      PH_ACMD41 = 3'd4,
      PH_CMD58  = 3'd5,
      PH_CMD16  = 3'd6,
      PH_DONE   = 3'd7
   } phase_type;

   // expected response format
   typedef enum logic [1:0] {
      KIND_R1 = 2'd0,
      KIND_R3 = 2'd1,
      KIND_R7 = 2'd2
   } kind_type;

   // command indexes
   localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
   localparam logic [5:0] CMD_SEND_IF    = 6'd8;
   localparam logic [5:0] CMD_SET_BLKLEN = 6'd16;
   localparam logic [5:0] CMD_SEND_OP    = 6'd41;
   localparam logic [5:0] CMD_APP        = 6'd55;
   localparam logic [5:0] CMD_READ_OCR   = 6'd58;

   // frame constants
   localparam logic [7:0]  CRC_CMD0   = 8'h95;
   localparam logic [7:0]  CRC_CMD8   = 8'h87;
   localparam logic [7:0]  CRC_NONE   = 8'hFF;
   localparam logic [31:0] CMD8_ARG   = 32'h0000_01AA;
   localparam logic [31:0] ACMD41_HCS = 32'h4000_0000;

   // response bits
   localparam logic [7:0] R1_IDLE        = 8'h01;
   localparam logic [7:0] R1_READY       = 8'h00;
   localparam logic [7:0] R1_ILLEGAL_BIT = 8'h04;
   localparam logic [7:0] OCR_CCS_BIT    = 8'h40;

   // one input transaction
   typedef struct packed {
      logic       command;
      logic [7:0] response_byte;
      logic [7:0] ocr_top_byte;
   } item_type;

   // one result transaction
   typedef struct packed {
      logic        send_valid;
      logic [5:0]  cmd_index;
      logic [31:0] cmd_arg;
      logic [7:0]  cmd_crc;
      kind_type    response_kind;
      logic        finished;
      logic        success;
      logic        card_v2;
      logic        card_high_capacity;
   } result_type;

   // sequencer state
   typedef struct packed {
      phase_type  phase;
      logic [7:0] attempt_count;
      logic       is_version2;
      logic       is_block_addressed;
      logic       init_done_ok;
   } seq_state_type;

   // configuration seen by the sequencer
   typedef struct packed {
      logic [7:0]  retry_limit;
      logic [11:0] block_length;
   } cfg_type;

endpackage

`default_nettype wire

>>> rtl/sdspi_csr.sv
// configuration registers behind the apb-style port
`default_nettype none

module sdspi_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [sdspi_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [sdspi_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [sdspi_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                   csr_pready,
   output sdspi_pkg::cfg_type                     cfg
);

   logic [7:0]  retry_limit_ff, retry_limit_in;
   logic [11:0] block_length_ff, block_length_in;
   logic        wr_en;
   logic [0:0]  reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   // register write
   always_comb begin
      retry_limit_in  = retry_limit_ff;
      block_length_in = block_length_ff;
      if (wr_en) begin
         case (reg_sel)
            sdspi_pkg::REG_RETRY_LIMIT:  retry_limit_in  = csr_pwdata[7:0];
            sdspi_pkg::REG_BLOCK_LENGTH: block_length_in = csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff  <= sdspi_pkg::RETRY_LIMIT_RST;
         block_length_ff <= sdspi_pkg::BLOCK_LENGTH_RST;
      end else begin
         retry_limit_ff  <= retry_limit_in;
         block_length_ff <= block_length_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         sdspi_pkg::REG_RETRY_LIMIT:  csr_prdata = {24'd0, retry_limit_ff};
         sdspi_pkg::REG_BLOCK_LENGTH: csr_prdata = {20'd0, block_length_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   assign cfg.retry_limit  = retry_limit_ff;
   assign cfg.block_length = block_length_ff;

endmodule

`default_nettype wire

>>> rtl/sdspi_step.sv
// next state and command frame for one transaction
`default_nettype none

module sdspi_step (
   input  wire sdspi_pkg::seq_state_type cur,
   input  wire sdspi_pkg::item_type      item,
   input  wire sdspi_pkg::cfg_type       cfg,
   output sdspi_pkg::seq_state_type      nxt,
   output sdspi_pkg::result_type         res
);

   logic retries_left;

   assign retries_left = cur.attempt_count < cfg.retry_limit;

   always_comb begin
      nxt = cur;
      res = '0;
      if (!item.command) begin
         // start restarts the whole sequence
         nxt.attempt_count      = 8'd1;
         nxt.is_version2        = 1'b0;
         nxt.is_block_addressed = 1'b0;
         nxt.init_done_ok       = 1'b0;
         nxt.phase              = sdspi_pkg::PH_CMD0;
         res.send_valid         = 1'b1;
         res.cmd_index          = sdspi_pkg::CMD_GO_IDLE;
         res.cmd_crc            = sdspi_pkg::CRC_CMD0;
         res.response_kind      = sdspi_pkg::KIND_R1;
      end else begin
         case (cur.phase)
            sdspi_pkg::PH_CMD0: begin
               if (item.response_byte == sdspi_pkg::R1_IDLE) begin
                  nxt.phase         = sdspi_pkg::PH_CMD8;
                  res.send_valid    = 1'b1;
                  res.cmd_index     = sdspi_pkg::CMD_SEND_IF;
                  res.cmd_arg       = sdspi_pkg::CMD8_ARG;
                  res.cmd_crc       = sdspi_pkg::CRC_CMD8;
                  res.response_kind = sdspi_pkg::KIND_R7;
               end else if (retries_left) begin
                  nxt.attempt_count = cur.attempt_count + 8'd1;
                  res.send_valid    = 1'b1;
                  res.cmd_index     = sdspi_pkg::CMD_GO_IDLE;
                  res.cmd_crc       = sdspi_pkg::CRC_CMD0;
                  res.response_kind = sdspi_pkg::KIND_R1;
               end else begin
                  nxt.phase        = sdspi_pkg::PH_DONE;
                  nxt.init_done_ok = 1'b0;
               end
            end
            sdspi_pkg::PH_CMD8: begin
               // illegal-command bit set means a version 1 card
               nxt.is_version2 =
                  (item.response_byte & sdspi_pkg::R1_ILLEGAL_BIT) == 8'd0;
               nxt.attempt_count = 8'd1;
               nxt.phase         = sdspi_pkg::PH_CMD55;
               res.send_valid    = 1'b1;
               res.cmd_index     = sdspi_pkg::CMD_APP;
               res.cmd_crc       = sdspi_pkg::CRC_NONE;
               res.response_kind = sdspi_pkg::KIND_R1;
            end
            sdspi_pkg::PH_CMD55: begin
               nxt.phase         = sdspi_pkg::PH_ACMD41;
               res.send_valid    = 1'b1;
               res.cmd_index     = sdspi_pkg::CMD_SEND_OP;
               res.cmd_arg       = cur.is_version2 ? sdspi_pkg::ACMD41_HCS : 32'd0;
               res.cmd_crc       = sdspi_pkg::CRC_NONE;
               res.response_kind = sdspi_pkg::KIND_R1;
            end
            sdspi_pkg::PH_ACMD41: begin
               if (item.response_byte == sdspi_pkg::R1_READY) begin
                  nxt.phase         = sdspi_pkg::PH_CMD58;
                  res.send_valid    = 1'b1;
                  res.cmd_index     = sdspi_pkg::CMD_READ_OCR;
                  res.cmd_crc       = sdspi_pkg::CRC_NONE;
                  res.response_kind = sdspi_pkg::KIND_R3;
               end else if (retries_left) begin
                  nxt.attempt_count = cur.attempt_count + 8'd1;
                  nxt.phase         = sdspi_pkg::PH_CMD55;
                  res.send_valid    = 1'b1;
                  res.cmd_index     = sdspi_pkg::CMD_APP;
                  res.cmd_crc       = sdspi_pkg::CRC_NONE;
                  res.response_kind = sdspi_pkg::KIND_R1;
               end else begin
                  nxt.phase        = sdspi_pkg::PH_DONE;
                  nxt.init_done_ok = 1'b0;
               end
            end
            sdspi_pkg::PH_CMD58: begin
               nxt.is_block_addressed =
                  (item.ocr_top_byte & sdspi_pkg::OCR_CCS_BIT) != 8'd0;
               if (nxt.is_block_addressed) begin
                  nxt.phase        = sdspi_pkg::PH_DONE;
                  nxt.init_done_ok = 1'b1;
               end else begin
                  nxt.phase         = sdspi_pkg::PH_CMD16;
                  res.send_valid    = 1'b1;
                  res.cmd_index     = sdspi_pkg::CMD_SET_BLKLEN;
                  res.cmd_arg       = {20'd0, cfg.block_length};
                  res.cmd_crc       = sdspi_pkg::CRC_NONE;
                  res.response_kind = sdspi_pkg::KIND_R1;
               end
            end
            sdspi_pkg::PH_CMD16: begin
               nxt.phase        = sdspi_pkg::PH_DONE;
               nxt.init_done_ok = item.response_byte == sdspi_pkg::R1_READY;
            end
            default: ;
         endcase
      end

      // status after this transaction
      res.finished           = nxt.phase == sdspi_pkg::PH_DONE;
      res.success            = res.finished & nxt.init_done_ok;
      res.card_v2            = nxt.is_version2;
      res.card_high_capacity = nxt.is_block_addressed;
   end

endmodule

`default_nettype wire

>>> rtl/sd_spi_init_sequencer.sv
// top level of the sd card spi init sequencer
// a transaction goes through the input register, then the result register
// throughput: one transaction per cycle while rsp_stall is low, set by
//   the single step of logic between the input and result registers
// reset: synchronous, clears the phase to idle, the card flags and both
//   pipeline valids; retry limit returns to 100 and block length to 512
`default_nettype none

module sd_spi_init_sequencer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_command,
   input  wire logic [7:0]                        req_response_byte,
   input  wire logic [7:0]                        req_ocr_top_byte,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_send_valid,
   output logic      [5:0]                        rsp_cmd_index,
   output logic      [31:0]                       rsp_cmd_arg,
   output logic      [7:0]                        rsp_cmd_crc,
   output logic      [1:0]                        rsp_response_kind,
   output logic                                   rsp_finished,
   output logic                                   rsp_success,
   output logic                                   rsp_card_v2,
   output logic                                   rsp_card_high_capacity,
   // configuration port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [sdspi_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [sdspi_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [sdspi_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                   csr_pready
);

   sdspi_pkg::cfg_type       cfg;
   sdspi_pkg::seq_state_type state_ff, state_in;
   sdspi_pkg::item_type      item_ff, item_in;
   sdspi_pkg::result_type    result_ff, result_in, step_res;
   logic                     in_valid_ff, in_valid_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     accept;
   logic                     advance;

   sdspi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sdspi_step u_step (
      .cur  (state_ff),
      .item (item_ff),
      .cfg  (cfg),
      .nxt  (state_in),
      .res  (step_res)
   );

   // handshake between input register and result register
   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      item_in.command       = req_command;
      item_in.response_byte = req_response_byte;
      item_in.ocr_top_byte  = req_ocr_top_byte;

      if (accept)       in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      else              in_valid_in = in_valid_ff;

      if (advance)        out_valid_in = 1'b1;
      else if (rsp_stall) out_valid_in = out_valid_ff;
      else                out_valid_in = 1'b0;

      result_in = advance ? step_res : result_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff              <= 1'b0;
         out_valid_ff             <= 1'b0;
         state_ff.phase           <= sdspi_pkg::PH_IDLE;
         state_ff.attempt_count   <= 8'd0;
         state_ff.is_version2     <= 1'b0;
         state_ff.is_block_addressed <= 1'b0;
         state_ff.init_done_ok    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_send_valid         = result_ff.send_valid;
   assign rsp_cmd_index          = result_ff.cmd_index;
   assign rsp_cmd_arg            = result_ff.cmd_arg;
   assign rsp_cmd_crc            = result_ff.cmd_crc;
   assign rsp_response_kind      = result_ff.response_kind;
   assign rsp_finished           = result_ff.finished;
   assign rsp_success            = result_ff.success;
   assign rsp_card_v2            = result_ff.card_v2;
   assign rsp_card_high_capacity = result_ff.card_high_capacity;

   // every step taken lands in the result register
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("step result not registered");

   // a held item is not dropped while the result side is stalled
   a_item_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && rsp_stall) |=> in_valid_ff)
      else $error("pending transaction lost");

   // success only reported with an ended sequence
   a_success_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (!rsp_success || rsp_finished))
      else $error("success without finished");

   // no frame means zero frame fields
   a_no_frame_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_send_valid) |->
         (rsp_cmd_index == 6'd0 && rsp_cmd_arg == 32'd0 &&
          rsp_cmd_crc == 8'd0 && rsp_response_kind == 2'd0))
      else $error("frame fields set without a frame");

endmodule

`default_nettype wire

>>> verif/sd_spi_init_sequencer_tb.sv
// self-checking testbench for the sd card spi init sequencer
`timescale 1ns / 100ps

module sd_spi_init_sequencer_tb;
   import sdspi_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 80;
   localparam int TAIL_CYCLES    = 10;

   // directed stimulus row, with an optional hand-written expectation
   typedef struct {
      item_type   stim;
      bit         literal;
      result_type frame;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = 1'b0;
   logic [7:0]  req_response_byte = '0;
   logic [7:0]  req_ocr_top_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_send_valid;
   logic [5:0]  rsp_cmd_index;
   logic [31:0] rsp_cmd_arg;
   logic [7:0]  rsp_cmd_crc;
   logic [1:0]  rsp_response_kind;
   logic        rsp_finished;
   logic        rsp_success;
   logic        rsp_card_v2;
   logic        rsp_card_high_capacity;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   // predicted sequencer state and register copy
   phase_type   st_phase;
   logic [7:0]  st_attempts;
   logic        st_v2;
   logic        st_hc;
   logic        st_ok;
   logic [7:0]  cfg_retry;
   logic [11:0] cfg_blk;

   result_type       pending_frames[$];
   directed_row_type directed_rows[$];
   int  mismatch_count = 0;
   int  stalled_cycles = 0;
   bit  calm = 1'b0;
   bit  hold_pending = 1'b0;

   sd_spi_init_sequencer uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_command            (req_command),
      .req_response_byte      (req_response_byte),
      .req_ocr_top_byte       (req_ocr_top_byte),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_send_valid         (rsp_send_valid),
      .rsp_cmd_index          (rsp_cmd_index),
      .rsp_cmd_arg            (rsp_cmd_arg),
      .rsp_cmd_crc            (rsp_cmd_crc),
      .rsp_response_kind      (rsp_response_kind),
      .rsp_finished           (rsp_finished),
      .rsp_success            (rsp_success),
      .rsp_card_v2            (rsp_card_v2),
      .rsp_card_high_capacity (rsp_card_high_capacity),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .csr_pready             (csr_pready)
   );

   always #10 clock = ~clock;

   // a command frame with status flags cleared
   function automatic result_type cmd_frame(logic [5:0] idx, logic [31:0] arg,
                                            logic [7:0] crc, kind_type kind);
      result_type r;
      r = '0;
      r.send_valid    = 1'b1;
      r.cmd_index     = idx;
      r.cmd_arg       = arg;
      r.cmd_crc       = crc;
      r.response_kind = kind;
      return r;
   endfunction

   function automatic result_type with_flags(result_type r, logic fin, logic ok,
                                             logic v2, logic hc);
      r.finished           = fin;
      r.success            = ok;
      r.card_v2            = v2;
      r.card_high_capacity = hc;
      return r;
   endfunction

   // next frame and status of the init sequence for one transaction
   function automatic result_type predict_init_step(item_type it);
      result_type r;
      r = '0;
      if (!it.command) begin
         st_attempts = 8'd1;
         st_v2       = 1'b0;
         st_hc       = 1'b0;
         st_ok       = 1'b0;
         r = cmd_frame(CMD_GO_IDLE, '0, CRC_CMD0, KIND_R1);
         st_phase = PH_CMD0;
      end else begin
         case (st_phase)
            PH_CMD0: begin
               if (it.response_byte == R1_IDLE) begin
                  r = cmd_frame(CMD_SEND_IF, CMD8_ARG, CRC_CMD8, KIND_R7);
                  st_phase = PH_CMD8;
               end else if (st_attempts < cfg_retry) begin
                  st_attempts = st_attempts + 8'd1;
                  r = cmd_frame(CMD_GO_IDLE, '0, CRC_CMD0, KIND_R1);
               end else begin
                  st_phase = PH_DONE;
                  st_ok    = 1'b0;
               end
            end
            PH_CMD8: begin
               st_v2       = ((it.response_byte & R1_ILLEGAL_BIT) == '0);
               st_attempts = 8'd1;
               r = cmd_frame(CMD_APP, '0, CRC_NONE, KIND_R1);
               st_phase = PH_CMD55;
            end
            PH_CMD55: begin
               r = cmd_frame(CMD_SEND_OP, st_v2 ? ACMD41_HCS : '0, CRC_NONE, KIND_R1);
               st_phase = PH_ACMD41;
            end
            PH_ACMD41: begin
               if (it.response_byte == R1_READY) begin
                  r = cmd_frame(CMD_READ_OCR, '0, CRC_NONE, KIND_R3);
                  st_phase = PH_CMD58;
               end else if (st_attempts < cfg_retry) begin
                  st_attempts = st_attempts + 8'd1;
                  r = cmd_frame(CMD_APP, '0, CRC_NONE, KIND_R1);
                  st_phase = PH_CMD55;
               end else begin
                  st_phase = PH_DONE;
                  st_ok    = 1'b0;
               end
            end
            PH_CMD58: begin
               st_hc = ((it.ocr_top_byte & OCR_CCS_BIT) != '0);
               if (st_hc) begin
                  st_phase = PH_DONE;
                  st_ok    = 1'b1;
               end else begin
                  r = cmd_frame(CMD_SET_BLKLEN, {20'd0, cfg_blk}, CRC_NONE, KIND_R1);
                  st_phase = PH_CMD16;
               end
            end
            PH_CMD16: begin
               st_phase = PH_DONE;
               st_ok    = (it.response_byte == R1_READY);
            end
            default: ;
         endcase
      end
      return with_flags(r, st_phase == PH_DONE, (st_phase == PH_DONE) && st_ok,
                        st_v2, st_hc);
   endfunction

   // card behavior: mostly well-formed replies for the pending command
   function automatic item_type card_reply(int ok_pct, int restart_pct);
      item_type it;
      int roll;
      it.command       = 1'b1;
      it.response_byte = 8'($urandom);
      it.ocr_top_byte  = 8'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < restart_pct) begin
         it.command = 1'b0;
      end else if (roll >= restart_pct + 5) begin
         case (st_phase)
            PH_CMD0: begin
               if ($urandom_range(0, 99) < ok_pct) it.response_byte = R1_IDLE;
               else if ($urandom_range(0, 1) == 1) it.response_byte = 8'hFF;
            end
            PH_CMD8: begin
               case ($urandom_range(0, 2))
                  0: it.response_byte = R1_IDLE;
                  1: it.response_byte = R1_IDLE | R1_ILLEGAL_BIT;
                  default: it.response_byte = 8'hFF;
               endcase
            end
            PH_CMD55: begin
               if ($urandom_range(0, 1) == 1) it.response_byte = R1_IDLE;
            end
            PH_ACMD41: begin
               it.response_byte = ($urandom_range(0, 99) < ok_pct) ? R1_READY : R1_IDLE;
            end
            PH_CMD58: it.response_byte = R1_READY;
            PH_CMD16: begin
               if ($urandom_range(0, 3) != 0) it.response_byte = R1_READY;
            end
            default: it.command = ($urandom_range(0, 9) == 0);
         endcase
      end
      return it;
   endfunction

   function automatic void add_row(logic cmd, logic [7:0] resp, logic [7:0] ocr,
                                   bit literal, result_type frame);
      directed_row_type row;
      row.stim.command       = cmd;
      row.stim.response_byte = resp;
      row.stim.ocr_top_byte  = ocr;
      row.literal            = literal;
      row.frame              = frame;
      directed_rows.push_back(row);
   endfunction

   // offer one transaction, record the expected frame once accepted
   task automatic put_item(item_type it, bit literal, result_type frame);
      result_type predicted;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= it.command;
      req_response_byte <= it.response_byte;
      req_ocr_top_byte  <= it.ocr_top_byte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_init_step(it);
      pending_frames.push_back(literal ? frame : predicted);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [0:0] reg_idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (reg_idx == REG_RETRY_LIMIT) cfg_retry = value[7:0];
      else cfg_blk = value[11:0];
      @(posedge clock);
   endtask

   // one random phase under a fresh register setting
   task automatic run_random(logic [7:0] retry, logic [11:0] blk, int n_items,
                             int ok_pct, int restart_pct, bit quiet, bit pressure);
      item_type it;
      int counted;
      bit held;
      counted = 0;
      held    = 1'b0;
      csr_write(REG_RETRY_LIMIT, {24'd0, retry});
      csr_write(REG_BLOCK_LENGTH, {20'd0, blk});
      calm = quiet;
      while (counted < n_items) begin
         it = card_reply(ok_pct, restart_pct);
         counted++;
         if (pressure && !held && counted >= 40) begin
            hold_pending = 1'b1;
            held = 1'b1;
         end
         put_item(it, 1'b0, '0);
      end
      drain();
   endtask

   // receiver: random stall bursts, and one long hold on request
   always begin
      @(posedge clock);
      if (hold_pending) begin
         hold_pending = 1'b0;
         rsp_stall <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // compare each accepted result transaction with the oldest expectation
   always @(posedge clock) begin : compare_results
      result_type got;
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.send_valid         = rsp_send_valid;
         got.cmd_index          = rsp_cmd_index;
         got.cmd_arg            = rsp_cmd_arg;
         got.cmd_crc            = rsp_cmd_crc;
         got.response_kind      = kind_type'(rsp_response_kind);
         got.finished           = rsp_finished;
         got.success            = rsp_success;
         got.card_v2            = rsp_card_v2;
         got.card_high_capacity = rsp_card_high_capacity;
         if (pending_frames.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result transaction: idx=%0d arg=%h", got.cmd_index,
                        got.cmd_arg);
         end else begin
            want = pending_frames.pop_front();
            if (got.send_valid !== want.send_valid || got.cmd_index !== want.cmd_index ||
                got.cmd_arg !== want.cmd_arg || got.cmd_crc !== want.cmd_crc ||
                got.response_kind !== want.response_kind ||
                got.finished !== want.finished || got.success !== want.success ||
                got.card_v2 !== want.card_v2 ||
                got.card_high_capacity !== want.card_high_capacity) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch exp: send=%b idx=%0d arg=%h crc=%h kind=%0d fin=%b ok=%b v2=%b hc=%b",
                           want.send_valid, want.cmd_index, want.cmd_arg, want.cmd_crc,
                           want.response_kind, want.finished, want.success, want.card_v2,
                           want.card_high_capacity);
                  $display("         got: send=%b idx=%0d arg=%h crc=%h kind=%0d fin=%b ok=%b v2=%b hc=%b",
                           got.send_valid, got.cmd_index, got.cmd_arg, got.cmd_crc,
                           got.response_kind, got.finished, got.success, got.card_v2,
                           got.card_high_capacity);
               end
            end
         end
      end
   end

   // watchdog on cycles without any accepted transaction
   initial begin
      while (stalled_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall))
            stalled_cycles = 0;
         else
            stalled_cycles++;
      end
      $display("[sd_spi_init_sequencer] ERROR");
      $finish;
   end

   initial begin
      result_type cmd0_fresh;
      st_phase    = PH_IDLE;
      st_attempts = '0;
      st_v2       = 1'b0;
      st_hc       = 1'b0;
      st_ok       = 1'b0;
      cfg_retry   = RETRY_LIMIT_RST;
      cfg_blk     = BLOCK_LENGTH_RST;
      cmd0_fresh  = with_flags(cmd_frame(CMD_GO_IDLE, '0, CRC_CMD0, KIND_R1),
                               1'b0, 1'b0, 1'b0, 1'b0);

      // directed walk at reset register values
      add_row(1'b1, R1_READY, 8'h00, 1'b1, '0);                  // response while idle
      add_row(1'b0, 8'hFF, 8'hFF, 1'b1, cmd0_fresh);
      add_row(1'b1, 8'hFF, 8'h00, 1'b1, cmd0_fresh);             // no response, retry cmd0
      add_row(1'b1, R1_IDLE, 8'h00, 1'b1,
              with_flags(cmd_frame(CMD_SEND_IF, CMD8_ARG, CRC_CMD8, KIND_R7),
                         1'b0, 1'b0, 1'b0, 1'b0));
      add_row(1'b1, 8'hFF, 8'h00, 1'b1,                          // cmd8 silent: version 1
              with_flags(cmd_frame(CMD_APP, '0, CRC_NONE, KIND_R1),
                         1'b0, 1'b0, 1'b0, 1'b0));
      add_row(1'b1, 8'hFF, 8'hFF, 1'b0, '0);                     // cmd55 r1 not checked
      add_row(1'b1, R1_IDLE, 8'h00, 1'b0, '0);                   // acmd41 busy
      add_row(1'b1, 8'h00, 8'h00, 1'b0, '0);
      add_row(1'b1, R1_READY, 8'h00, 1'b0, '0);
      add_row(1'b1, R1_READY, 8'h00, 1'b0, '0);                  // standard capacity
      add_row(1'b1, R1_ILLEGAL_BIT, 8'h00, 1'b1,
              with_flags('0, 1'b1, 1'b0, 1'b0, 1'b0));
      add_row(1'b1, R1_READY, 8'hFF, 1'b0, '0);                  // response while finished
      add_row(1'b0, 8'h00, 8'h00, 1'b0, '0);
      add_row(1'b1, R1_IDLE, 8'h00, 1'b0, '0);
      add_row(1'b1, R1_IDLE, 8'h00, 1'b0, '0);                   // version 2
      add_row(1'b1, 8'h00, 8'h00, 1'b0, '0);                     // acmd41 with hcs
      add_row(1'b1, R1_READY, 8'h00, 1'b0, '0);
      add_row(1'b1, 8'h00, 8'hC0, 1'b1,                          // high capacity
              with_flags('0, 1'b1, 1'b1, 1'b1, 1'b1));
      add_row(1'b0, 8'hFF, 8'hFF, 1'b1, cmd0_fresh);             // restart clears flags
      add_row(1'b1, R1_IDLE, 8'h00, 1'b0, '0);
      add_row(1'b1, R1_IDLE | R1_ILLEGAL_BIT, 8'h00, 1'b0, '0);  // illegal command
      add_row(1'b1, 8'hFF, 8'h00, 1'b0, '0);
      add_row(1'b1, R1_READY, 8'h00, 1'b0, '0);
      add_row(1'b1, 8'hFF, 8'hBF, 1'b0, '0);                     // ccs clear, rest set
      add_row(1'b0, 8'h00, 8'h00, 1'b0, '0);                     // start while running

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         put_item(directed_rows[i].stim, directed_rows[i].literal, directed_rows[i].frame);
      drain();

      // random phases: extremes, zero values, then random settings
      run_random(8'd1, 12'd1, 150, 60, 4, 1'b0, 1'b0);
      run_random(8'd255, 12'd2048, 300, 0, 0, 1'b0, 1'b0);
      run_random(8'd0, 12'd0, 150, 50, 4, 1'b0, 1'b0);
      run_random(8'($urandom_range(2, 6)), 12'($urandom_range(1, 2048)), 150, 50, 4,
                 1'b1, 1'b0);
      run_random(8'd100, 12'($urandom_range(1, 2048)), 150, 70, 4, 1'b0, 1'b1);
      run_random(8'($urandom_range(1, 255)), 12'($urandom_range(1, 2048)), 200, 60, 4,
                 1'b1, 1'b0);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[sd_spi_init_sequencer] OK");
      else
         $display("[sd_spi_init_sequencer] ERROR");
      $finish;
   end

endmodule

>>> sd_spi_init_sequencer.f
rtl/sdspi_pkg.sv
rtl/sdspi_csr.sv
rtl/sdspi_step.sv
rtl/sd_spi_init_sequencer.sv
verif/sd_spi_init_sequencer_tb.sv
